// ----- rtl/stt_pkg.sv -----
// shared types and constants for the source text tokenizer
package stt_pkg;

  // scanner mode between input words
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ID   = 3'd1,
    MODE_INT  = 3'd2,
    MODE_STR  = 3'd3,
    MODE_EQ   = 3'd4,
    MODE_ERR  = 3'd5
  } mode_t;

  // token kind codes
  localparam logic [4:0] KIND_ID    = 5'd0;
  localparam logic [4:0] KIND_INT   = 5'd1;
  localparam logic [4:0] KIND_STR   = 5'd2;
  localparam logic [4:0] KIND_EQ    = 5'd3;
  localparam logic [4:0] KIND_ARROW = 5'd4;
  localparam logic [4:0] KIND_LPAR  = 5'd5;
  localparam logic [4:0] KIND_RPAR  = 5'd6;
  localparam logic [4:0] KIND_LBRC  = 5'd7;
  localparam logic [4:0] KIND_RBRC  = 5'd8;
  localparam logic [4:0] KIND_LBRK  = 5'd9;
  localparam logic [4:0] KIND_RBRK  = 5'd10;
  localparam logic [4:0] KIND_COLON = 5'd11;
  localparam logic [4:0] KIND_COMMA = 5'd12;
  localparam logic [4:0] KIND_LT    = 5'd13;
  localparam logic [4:0] KIND_GT    = 5'd14;
  localparam logic [4:0] KIND_SEMI  = 5'd15;
  localparam logic [4:0] KIND_EOF   = 5'd16;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  // one result word
  typedef struct packed {
    logic [4:0] token_kind;
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       token_first;
    logic       token_last;
    logic       lex_error;
    logic       last_of_step;
  } res_t;

  // outcome of scanning one byte between tokens
  typedef struct packed {
    logic  has;
    res_t  res;
    mode_t mode;
  } idle_t;

  localparam res_t RES_NONE = '0;

  // build a result word; value is zeroed when not valid
  function automatic res_t mk_res(logic [4:0] kind, logic [7:0] val, logic vld,
                                  logic first, logic last, logic err);
    res_t r;
    r.token_kind   = kind;
    r.value_byte   = vld ? val : 8'h00;
    r.byte_valid   = vld;
    r.token_first  = first;
    r.token_last   = last;
    r.lex_error    = err;
    r.last_of_step = 1'b0;
    return r;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // handling of a byte seen between tokens
  function automatic idle_t scan_idle(logic [7:0] c);
    idle_t o;
    o.has  = 1'b1;
    o.res  = RES_NONE;
    o.mode = MODE_IDLE;
    priority if (c == CH_CR || c == CH_LF || c == CH_SPACE || c == CH_TAB) begin
      o.has = 1'b0;
    end else if (is_letter(c)) begin
      o.res  = mk_res(KIND_ID, c, 1'b1, 1'b1, 1'b0, 1'b0);
      o.mode = MODE_ID;
    end else if (is_digit(c)) begin
      o.res  = mk_res(KIND_INT, c, 1'b1, 1'b1, 1'b0, 1'b0);
      o.mode = MODE_INT;
    end else if (c == CH_EQ) begin
      o.has  = 1'b0;
      o.mode = MODE_EQ;
    end else if (c == CH_QUOTE) begin
      o.res  = mk_res(KIND_STR, CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
      o.mode = MODE_STR;
    end else if (c == CH_NUL) begin
      o.res  = mk_res(KIND_EOF, CH_NUL, 1'b0, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_LPAR) begin
      o.res  = mk_res(KIND_LPAR, c, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_RPAR) begin
      o.res  = mk_res(KIND_RPAR, c, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_LBRC) begin
      o.res  = mk_res(KIND_LBRC, c, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_RBRC) begin
      o.res  = mk_res(KIND_RBRC, c, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_LBRK) begin
      o.res  = mk_res(KIND_LBRK, c, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_RBRK) begin
      o.res  = mk_res(KIND_RBRK, c, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_COLON) begin
      o.res  = mk_res(KIND_COLON, c, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_COMMA) begin
      o.res  = mk_res(KIND_COMMA, c, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_LT) begin
      o.res  = mk_res(KIND_LT, c, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_GT) begin
      o.res  = mk_res(KIND_GT, c, 1'b1, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_SEMI) begin
      o.res  = mk_res(KIND_SEMI, c, 1'b1, 1'b1, 1'b1, 1'b0);
    end else begin
      o.res  = mk_res(KIND_ID, CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
      o.mode = MODE_ERR;
    end
    return o;
  endfunction

endpackage

// ----- rtl/source_text_tokenizer_core.sv -----
// source text tokenizer: byte stream in, token byte words out
//
// Input channel: in_valid / in_stall carry one source byte per word
// (in_char_byte), byte 0 closing the text. Output channel: out_valid /
// out_stall carry one token result per word with kind, byte, first/last
// marks, error flag and a mark on the last word caused by an input byte.
// A byte yields zero, one or two result words.
// The byte is decoded against the scan mode in the same cycle it is
// accepted and its words are written to a four-entry result queue; from
// an empty queue the first word is visible in the cycle after acceptance.
// Throughput is one input byte per cycle while bytes yield at most one
// word and out_stall is low; the output port pops one word per cycle,
// so an '=>' arrow's words leave in turn. in_stall rises when the queue
// holds three or more words, since a byte may need two free entries.
// Reset (synchronous, rst_n low) empties the queue and returns the scan
// mode to idle, clearing a sticky error. While out_stall is high the head
// word holds and the queue fills, then in_stall rises.
module source_text_tokenizer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_token_kind,
  output logic [7:0] out_value_byte,
  output logic       out_byte_valid,
  output logic       out_token_first,
  output logic       out_token_last,
  output logic       out_lex_error,
  output logic       out_last_of_step
);
  import stt_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  mode_t            mode_r, mode_nxt;
  res_t             q_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, rptr_r;
  logic [QAW:0]     cnt_r;
  res_t             slot0, slot1;
  logic [1:0]       nres;
  idle_t            idl;
  logic             in_acc, out_acc;
  logic [QAW-1:0]   wptr_p1;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign wptr_p1 = wptr_r + 1'b1;

  // decode of the incoming byte against the current mode
  always_comb begin
    idl      = scan_idle(in_char_byte);
    slot0    = RES_NONE;
    slot1    = RES_NONE;
    nres     = 2'd0;
    mode_nxt = mode_r;
    unique case (mode_r)
      MODE_ID, MODE_INT: begin
        if ((mode_r == MODE_ID) ? is_letter(in_char_byte) : is_digit(in_char_byte)) begin
          slot0 = mk_res((mode_r == MODE_ID) ? KIND_ID : KIND_INT, in_char_byte,
                         1'b1, 1'b0, 1'b0, 1'b0);
          nres  = 2'd1;
        end else begin
          slot0    = mk_res((mode_r == MODE_ID) ? KIND_ID : KIND_INT, CH_NUL,
                            1'b0, 1'b0, 1'b1, 1'b0);
          slot1    = idl.res;
          nres     = idl.has ? 2'd2 : 2'd1;
          mode_nxt = idl.mode;
        end
      end
      MODE_STR: begin
        nres = 2'd1;
        if (in_char_byte == CH_QUOTE) begin
          slot0    = mk_res(KIND_STR, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0);
          mode_nxt = MODE_IDLE;
        end else if (in_char_byte == CH_NUL) begin
          slot0    = mk_res(KIND_ID, CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
          mode_nxt = MODE_ERR;
        end else begin
          slot0 = mk_res(KIND_STR, in_char_byte, 1'b1, 1'b0, 1'b0, 1'b0);
        end
      end
      MODE_EQ: begin
        if (in_char_byte == CH_GT) begin
          slot0    = mk_res(KIND_ARROW, CH_EQ, 1'b1, 1'b1, 1'b0, 1'b0);
          slot1    = mk_res(KIND_ARROW, CH_GT, 1'b1, 1'b0, 1'b1, 1'b0);
          nres     = 2'd2;
          mode_nxt = MODE_IDLE;
        end else begin
          slot0    = mk_res(KIND_EQ, CH_EQ, 1'b1, 1'b1, 1'b1, 1'b0);
          slot1    = idl.res;
          nres     = idl.has ? 2'd2 : 2'd1;
          mode_nxt = idl.mode;
        end
      end
      MODE_IDLE: begin
        slot0    = idl.res;
        nres     = idl.has ? 2'd1 : 2'd0;
        mode_nxt = idl.mode;
      end
      default: begin
        slot0    = mk_res(KIND_ID, CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
        nres     = 2'd1;
        mode_nxt = MODE_ERR;
      end
    endcase
    // mark the final word of this byte
    if (nres == 2'd2) begin
      slot1.last_of_step = 1'b1;
    end else begin
      slot0.last_of_step = 1'b1;
    end
  end

  // scan mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (in_acc && (nres != 2'd0)) begin
      q_r[wptr_r] <= slot0;
    end
    if (in_acc && (nres == 2'd2)) begin
      q_r[wptr_p1] <= slot1;
    end
  end

  // result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (in_acc) begin
        wptr_r <= wptr_r + QAW'(nres);
      end
      if (out_acc) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (in_acc ? (QAW+1)'(nres) : '0) - (QAW+1)'(out_acc);
    end
  end

  // handshake and output word
  assign in_stall         = (cnt_r > (QAW+1)'(QDEPTH - 2));
  assign out_valid        = (cnt_r != '0);
  assign out_token_kind   = q_r[rptr_r].token_kind;
  assign out_value_byte   = q_r[rptr_r].value_byte;
  assign out_byte_valid   = q_r[rptr_r].byte_valid;
  assign out_token_first  = q_r[rptr_r].token_first;
  assign out_token_last   = q_r[rptr_r].token_last;
  assign out_lex_error    = q_r[rptr_r].lex_error;
  assign out_last_of_step = q_r[rptr_r].last_of_step;

  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("result queue count above depth");

  // a byte is taken only with room for two words
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (cnt_r <= (QAW+1)'(QDEPTH - 2)))
    else $error("byte accepted without room for two words");

  // error mode is sticky until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ERR) |=> (mode_r == MODE_ERR))
    else $error("error mode left without reset");

  // a byte taken in error mode leaves a word queued
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (mode_r == MODE_ERR)) |=> out_valid)
    else $error("no error word after byte in error mode");

endmodule

// ----- verif/stt_token_checker.sv -----
// token stream checker: predicts the result words of each accepted byte and compares them
`timescale 1ns / 1ps

module stt_token_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [4:0] out_token_kind,
  input  logic [7:0] out_value_byte,
  input  logic       out_byte_valid,
  input  logic       out_token_first,
  input  logic       out_token_last,
  input  logic       out_lex_error,
  input  logic       out_last_of_step,
  output int         mismatches,
  output int         words_pending
);
  import stt_pkg::*;

  // scanner state as the block should hold it
  mode_t scan_mode;
  // words still owed by the block, oldest first
  res_t  tokens_due[$];
  // words produced by the byte being scanned
  res_t  step_words[$];

  function automatic logic alpha(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic numeral(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic blank(input logic [7:0] b);
    return b == CH_CR || b == CH_LF || b == CH_SPACE || b == CH_TAB;
  endfunction

  // single-character punctuation lookup
  function automatic logic punct_lookup(input logic [7:0] b, output logic [4:0] kind);
    kind = KIND_ID;
    punct_lookup = 1'b1;
    case (b)
      CH_LPAR:  kind = KIND_LPAR;
      CH_RPAR:  kind = KIND_RPAR;
      CH_LBRC:  kind = KIND_LBRC;
      CH_RBRC:  kind = KIND_RBRC;
      CH_LBRK:  kind = KIND_LBRK;
      CH_RBRK:  kind = KIND_RBRK;
      CH_COLON: kind = KIND_COLON;
      CH_COMMA: kind = KIND_COMMA;
      CH_LT:    kind = KIND_LT;
      CH_GT:    kind = KIND_GT;
      CH_SEMI:  kind = KIND_SEMI;
      default:  punct_lookup = 1'b0;
    endcase
  endfunction

  // append one word; the byte only travels when it is marked valid
  task automatic add_word(input logic [4:0] kind, input logic [7:0] b, input logic has_byte,
                          input logic first, input logic last, input logic err);
    res_t w;
    w.token_kind   = kind;
    w.value_byte   = has_byte ? b : 8'h00;
    w.byte_valid   = has_byte;
    w.token_first  = first;
    w.token_last   = last;
    w.lex_error    = err;
    w.last_of_step = 1'b0;
    step_words.push_back(w);
  endtask

  // a byte seen with no token open
  task automatic between_tokens(input logic [7:0] b);
    logic [4:0] pk;
    if (blank(b)) begin
      scan_mode = MODE_IDLE;
    end else if (alpha(b)) begin
      add_word(KIND_ID, b, 1'b1, 1'b1, 1'b0, 1'b0);
      scan_mode = MODE_ID;
    end else if (numeral(b)) begin
      add_word(KIND_INT, b, 1'b1, 1'b1, 1'b0, 1'b0);
      scan_mode = MODE_INT;
    end else if (b == CH_EQ) begin
      scan_mode = MODE_EQ;
    end else if (b == CH_QUOTE) begin
      add_word(KIND_STR, CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
      scan_mode = MODE_STR;
    end else if (b == CH_NUL) begin
      add_word(KIND_EOF, CH_NUL, 1'b0, 1'b1, 1'b1, 1'b0);
      scan_mode = MODE_IDLE;
    end else if (punct_lookup(b, pk)) begin
      add_word(pk, b, 1'b1, 1'b1, 1'b1, 1'b0);
    end else begin
      // stray byte: sticky error
      add_word(KIND_ID, CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
      scan_mode = MODE_ERR;
    end
  endtask

  // scan one accepted byte and queue the words it owes
  task automatic scan_byte(input logic [7:0] b);
    logic [4:0] kind;
    logic       more;
    step_words.delete();
    case (scan_mode)
      MODE_ID, MODE_INT: begin
        kind = (scan_mode == MODE_ID) ? KIND_ID : KIND_INT;
        more = (scan_mode == MODE_ID) ? alpha(b) : numeral(b);
        if (more) begin
          add_word(kind, b, 1'b1, 1'b0, 1'b0, 1'b0);
        end else begin
          // close the run, then treat the byte as a fresh one
          add_word(kind, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0);
          scan_mode = MODE_IDLE;
          between_tokens(b);
        end
      end
      MODE_STR: begin
        if (b == CH_QUOTE) begin
          add_word(KIND_STR, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b0);
          scan_mode = MODE_IDLE;
        end else if (b == CH_NUL) begin
          // text ended inside a string
          add_word(KIND_ID, CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
          scan_mode = MODE_ERR;
        end else begin
          add_word(KIND_STR, b, 1'b1, 1'b0, 1'b0, 1'b0);
        end
      end
      MODE_EQ: begin
        if (b == CH_GT) begin
          add_word(KIND_ARROW, CH_EQ, 1'b1, 1'b1, 1'b0, 1'b0);
          add_word(KIND_ARROW, CH_GT, 1'b1, 1'b0, 1'b1, 1'b0);
          scan_mode = MODE_IDLE;
        end else begin
          // lone equals, then the lookahead byte on its own
          add_word(KIND_EQ, CH_EQ, 1'b1, 1'b1, 1'b1, 1'b0);
          scan_mode = MODE_IDLE;
          between_tokens(b);
        end
      end
      MODE_IDLE: between_tokens(b);
      default: begin
        add_word(KIND_ID, CH_NUL, 1'b0, 1'b0, 1'b0, 1'b1);
        scan_mode = MODE_ERR;
      end
    endcase
    if (step_words.size() > 0) step_words[step_words.size() - 1].last_of_step = 1'b1;
    foreach (step_words[i]) tokens_due.push_back(step_words[i]);
  endtask

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  // output side first: a word leaving now was owed by an earlier byte
  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      scan_mode  = MODE_IDLE;
      mismatches = 0;
      tokens_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          $error("word with none expected: kind %0h byte %0h", out_token_kind, out_value_byte);
          mismatches++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", 8'(want.token_kind), 8'(out_token_kind));
          check_field("value_byte", want.value_byte, out_value_byte);
          check_field("byte_valid", 8'(want.byte_valid), 8'(out_byte_valid));
          check_field("token_first", 8'(want.token_first), 8'(out_token_first));
          check_field("token_last", 8'(want.token_last), 8'(out_token_last));
          check_field("lex_error", 8'(want.lex_error), 8'(out_lex_error));
          check_field("last_of_step", 8'(want.last_of_step), 8'(out_last_of_step));
        end
      end
      if (in_valid && !in_stall) scan_byte(in_char_byte);
    end
    words_pending <= tokens_due.size();
  end

endmodule

// ----- verif/tb_source_text_tokenizer_core.sv -----
// testbench top: drives source text into the tokenizer and gives the verdict
`timescale 1ns / 1ps

module tb_source_text_tokenizer_core;
  import stt_pkg::*;

  localparam int QUIET_LIMIT   = 1000;
  localparam int RANDOM_BYTES  = 400;
  localparam int DRAIN_SPACING = 150;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_char_byte = 8'h00;
  logic       out_stall    = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [4:0] out_token_kind;
  logic [7:0] out_value_byte;
  logic       out_byte_valid;
  logic       out_token_first;
  logic       out_token_last;
  logic       out_lex_error;
  logic       out_last_of_step;
  int         mismatches;
  int         words_pending;

  // pacing state for both sides
  bit         in_steady  = 1'b0;
  bit         out_steady = 1'b0;
  int         bytes_sent = 0;

  // letters and digit extremes, a string with high and low bytes, arrow,
  // lone equals before another equals, every punctuator, end of text
  logic [7:0] opening_text [25] = '{
    "A", "z", "0", "9", CH_TAB,
    CH_QUOTE, 8'hFF, 8'h01, CH_QUOTE,
    CH_EQ, CH_GT,
    CH_EQ, CH_EQ, CH_LPAR,
    CH_RPAR, CH_LBRC, CH_RBRC, CH_LBRK, CH_RBRK, CH_COLON, CH_COMMA, CH_LT, CH_GT, CH_SEMI,
    CH_NUL
  };

  logic [7:0] punct_set [11] = '{
    CH_LPAR, CH_RPAR, CH_LBRC, CH_RBRC, CH_LBRK, CH_RBRK, CH_COLON, CH_COMMA, CH_LT, CH_GT,
    CH_SEMI
  };

  logic [7:0] blank_set [4] = '{CH_CR, CH_LF, CH_SPACE, CH_TAB};

  // printable bytes that start no token
  logic [7:0] stray_set [16] = '{
    "!", "#", "$", "%", "&", "*", "+", "-", ".", "/", "?", "@", "^", "_", "|", "~"
  };

  source_text_tokenizer_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_value_byte   (out_value_byte),
    .out_byte_valid   (out_byte_valid),
    .out_token_first  (out_token_first),
    .out_token_last   (out_token_last),
    .out_lex_error    (out_lex_error),
    .out_last_of_step (out_last_of_step)
  );

  stt_token_checker u_token_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_value_byte   (out_value_byte),
    .out_byte_valid   (out_byte_valid),
    .out_token_first  (out_token_first),
    .out_token_last   (out_token_last),
    .out_lex_error    (out_lex_error),
    .out_last_of_step (out_last_of_step),
    .mismatches       (mismatches),
    .words_pending    (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one source byte: random gap, then hold until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // hold off the sender until every owed word is out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    @(posedge clk);
  endtask

  // one well-formed token with random content
  task automatic emit_token();
    int         pick;
    int         n;
    logic [7:0] ch;
    if ($urandom_range(0, 29) == 0) in_steady = !in_steady;
    pick = $urandom_range(0, 19);
    if (pick <= 3) begin
      // identifier
      n = $urandom_range(1, 6);
      repeat (n) begin
        ch = ($urandom_range(0, 1) ? "A" : "a") + 8'($urandom_range(0, 25));
        send_byte(ch);
      end
    end else if (pick <= 6) begin
      // integer
      n = $urandom_range(1, 6);
      repeat (n) send_byte("0" + 8'($urandom_range(0, 9)));
    end else if (pick <= 8) begin
      // string with any nonzero content but the quote
      send_byte(CH_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) begin
        do ch = 8'($urandom_range(1, 255)); while (ch == CH_QUOTE);
        send_byte(ch);
      end
      send_byte(CH_QUOTE);
    end else if (pick <= 11) begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(blank_set[$urandom_range(0, 3)]);
    end else if (pick == 12) begin
      send_byte(CH_EQ);
    end else if (pick == 13) begin
      send_byte(CH_EQ);
      send_byte(CH_GT);
    end else if (pick <= 17) begin
      send_byte(punct_set[$urandom_range(0, 10)]);
    end else if (pick == 18) begin
      send_byte(CH_NUL);
    end else begin
      send_byte(CH_SPACE);
    end
  endtask

  // result side: random stall per word, with quiet stretches
  initial begin
    int hold;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
      hold = out_steady ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int         next_drain;
    int         n;
    logic [7:0] ch;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_text[i]) send_byte(opening_text[i]);
    wait_for_drain();

    // random well-formed text, drained now and then
    next_drain = bytes_sent + DRAIN_SPACING;
    while (bytes_sent < RANDOM_BYTES + 25) begin
      emit_token();
      if (bytes_sent >= next_drain) begin
        wait_for_drain();
        next_drain = bytes_sent + DRAIN_SPACING;
      end
    end

    // the error is sticky, so it closes the run
    if ($urandom_range(0, 1)) begin
      // text ends inside a string
      send_byte(CH_QUOTE);
      n = $urandom_range(0, 3);
      repeat (n) send_byte("a" + 8'($urandom_range(0, 25)));
      send_byte(CH_NUL);
    end else begin
      // byte that starts no token
      if ($urandom_range(0, 1)) ch = 8'($urandom_range(128, 255));
      else ch = stray_set[$urandom_range(0, 15)];
      send_byte(ch);
    end
    // anything after is an error word
    repeat (20) send_byte(8'($urandom_range(0, 255)));

    wait_for_drain();
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && words_pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
